// ===== rtl/core/aprs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aprs_pkg;

  localparam int POS_W = 5;
  localparam int OFF_W = 4;
  localparam int CNT_W = 6;
  localparam int LAT_W = 21;
  localparam int LON_W = 22;
  localparam int LAT_MAG_W = 20;
  localparam int LON_MAG_W = 21;

  localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_AT    = 8'h40;  // '@'
  localparam logic [7:0] CH_POINT = 8'h2E;  // '.'
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [OFF_W-1:0] OFFSET_NOW   = 4'd1;
  localparam logic [OFF_W-1:0] OFFSET_TIMED = 4'd8;
  localparam logic [POS_W-1:0] POS_MAX      = 5'd31;
  localparam logic [POS_W-1:0] REL_SYM_TBL  = 5'd8;
  localparam logic [POS_W-1:0] REL_LON0     = 5'd9;
  localparam logic [POS_W-1:0] REL_SYM_CODE = 5'd18;
  localparam logic [POS_W-1:0] REL_LAST_POS = 5'd18;

  localparam int LAT_DEG_MAX  = 90;
  localparam int LON_DEG_MAX  = 180;
  localparam int MINUTE_SCALE = 6000;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_TYPE  = 3'd1,
    ERR_SHORT = 3'd2,
    ERR_LAT   = 3'd3,
    ERR_LON   = 3'd4
  } aprs_err_t;

  typedef struct packed {
    logic                    kind;
    logic [7:0]              comment_char;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    logic [7:0]              sym_table;
    logic [7:0]              sym_code;
    logic                    pos_valid;
    aprs_err_t               error_code;
    logic [CNT_W-1:0]        comment_length;
    logic                    record_last;
  } aprs_result_t;

  typedef struct packed {
    logic         comment_valid;
    logic         record_valid;
    aprs_result_t comment;
    aprs_result_t record;
  } aprs_emit_t;

  typedef struct packed {
    logic not_empty;
    logic room_for_two;
  } aprs_queue_status_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aprs_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aprs_frame_decoder #(
  parameter int COMMENT_LIMIT = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output aprs_pkg::aprs_emit_t emit
);
  import aprs_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [OFF_W-1:0] position_offset, position_offset_next;
  logic [6:0]       lat_degrees, lat_degrees_next;
  logic [13:0]      lat_minutes, lat_minutes_next;
  logic [7:0]       lon_degrees, lon_degrees_next;
  logic [13:0]      lon_minutes, lon_minutes_next;
  logic [1:0]       hemisphere, hemisphere_next;
  logic [15:0]      held_symbols, held_symbols_next;
  aprs_err_t        frame_error, frame_error_next;
  logic [CNT_W-1:0] comment_count, comment_count_next;

  function automatic logic [17:0] times_ten_plus(input logic [13:0] v, input logic [3:0] d);
    return 18'({v, 3'b000}) + 18'({v, 1'b0}) + 18'(d);
  endfunction

  logic [LAT_MAG_W-1:0] lat_mag;
  logic [LON_MAG_W-1:0] lon_mag;
  logic [LAT_W-1:0]     lat_val;
  logic [LON_W-1:0]     lon_val;

  // magnitudes from the held fields; a good record never has its last byte in these fields
  assign lat_mag = LAT_MAG_W'(lat_degrees) * LAT_MAG_W'(MINUTE_SCALE) + LAT_MAG_W'(lat_minutes);
  assign lon_mag = LON_MAG_W'(lon_degrees) * LON_MAG_W'(MINUTE_SCALE) + LON_MAG_W'(lon_minutes);
  assign lat_val = hemisphere[0] ? LAT_W'(0) - LAT_W'(lat_mag) : LAT_W'(lat_mag);
  assign lon_val = hemisphere[1] ? LON_W'(0) - LON_W'(lon_mag) : LON_W'(lon_mag);

  always_comb begin
    logic [POS_W-1:0] rel;
    logic [2:0]       k_lat;
    logic [3:0]       k_lon;
    logic [3:0]       digit;
    logic [10:0]      lon_acc;
    aprs_err_t        final_err;

    byte_position_next   = byte_position;
    position_offset_next = position_offset;
    lat_degrees_next     = lat_degrees;
    lat_minutes_next     = lat_minutes;
    lon_degrees_next     = lon_degrees;
    lon_minutes_next     = lon_minutes;
    hemisphere_next      = hemisphere;
    held_symbols_next    = held_symbols;
    frame_error_next     = frame_error;
    comment_count_next   = comment_count;

    rel     = byte_position - POS_W'(position_offset);
    k_lat   = rel[2:0];
    k_lon   = 4'(rel - REL_LON0);
    digit   = data_byte[3:0];
    lon_acc = 11'(times_ten_plus(14'(lon_degrees), digit));

    emit = '0;
    emit.comment.comment_char = data_byte;

    if (byte_position == '0) begin
      if (data_byte == CH_BANG || data_byte == CH_EQUAL) begin
        position_offset_next = OFFSET_NOW;
      end else if (data_byte == CH_SLASH || data_byte == CH_AT) begin
        position_offset_next = OFFSET_TIMED;
      end else begin
        frame_error_next = ERR_TYPE;
      end
    end else if (frame_error == ERR_NONE && byte_position >= POS_W'(position_offset)) begin
      if (rel < REL_SYM_TBL) begin
        // latitude DDMM.MM then N/S
        priority if (k_lat == 3'd4) begin
          if (data_byte != CH_POINT) frame_error_next = ERR_LAT;
        end else if (k_lat == 3'd7) begin
          if (data_byte == CH_S) begin
            hemisphere_next[0] = 1'b1;
          end else if (data_byte != CH_N) begin
            frame_error_next = ERR_LAT;
          end
          if (lat_degrees > 7'(LAT_DEG_MAX) || lat_minutes >= 14'(MINUTE_SCALE)) begin
            frame_error_next = ERR_LAT;
          end
        end else if (!is_digit(data_byte)) begin
          frame_error_next = ERR_LAT;
        end else if (k_lat < 3'd2) begin
          lat_degrees_next = 7'(times_ten_plus(14'(lat_degrees), digit));
        end else begin
          lat_minutes_next = 14'(times_ten_plus(lat_minutes, digit));
        end
      end else if (rel == REL_SYM_TBL) begin
        held_symbols_next[15:8] = data_byte;
      end else if (rel < REL_SYM_CODE) begin
        // longitude DDDMM.MM then E/W
        priority if (k_lon == 4'd5) begin
          if (data_byte != CH_POINT) frame_error_next = ERR_LON;
        end else if (k_lon == 4'd8) begin
          if (data_byte == CH_W) begin
            hemisphere_next[1] = 1'b1;
          end else if (data_byte != CH_E) begin
            frame_error_next = ERR_LON;
          end
          if (lon_minutes >= 14'(MINUTE_SCALE)) frame_error_next = ERR_LON;
        end else if (!is_digit(data_byte)) begin
          frame_error_next = ERR_LON;
        end else if (k_lon < 4'd3) begin
          if (lon_acc > 11'(LON_DEG_MAX)) begin
            frame_error_next = ERR_LON;
            lon_degrees_next = 8'(LON_DEG_MAX);
          end else begin
            lon_degrees_next = lon_acc[7:0];
          end
        end else begin
          lon_minutes_next = 14'(times_ten_plus(lon_minutes, digit));
        end
      end else if (rel == REL_SYM_CODE) begin
        held_symbols_next[7:0] = data_byte;
      end else if (comment_count < CNT_W'(COMMENT_LIMIT)) begin
        emit.comment_valid = 1'b1;
        comment_count_next = comment_count + CNT_W'(1);
      end
    end

    if (byte_position < POS_MAX) byte_position_next = byte_position + POS_W'(1);

    final_err = frame_error_next;
    if (final_err != ERR_TYPE &&
        byte_position < POS_W'(position_offset_next) + REL_LAST_POS) begin
      final_err = ERR_SHORT;
    end

    emit.record_valid       = last_byte;
    emit.record.kind        = 1'b1;
    emit.record.record_last = 1'b1;
    emit.record.error_code  = final_err;
    if (final_err == ERR_NONE) begin
      emit.record.latitude       = $signed(lat_val);
      emit.record.longitude      = $signed(lon_val);
      emit.record.sym_table      = held_symbols_next[15:8];
      emit.record.sym_code       = held_symbols_next[7:0];
      emit.record.pos_valid      = 1'b1;
      emit.record.comment_length = comment_count_next;
    end

    if (last_byte) begin
      byte_position_next   = '0;
      position_offset_next = '0;
      lat_degrees_next     = '0;
      lat_minutes_next     = '0;
      lon_degrees_next     = '0;
      lon_minutes_next     = '0;
      hemisphere_next      = '0;
      held_symbols_next    = '0;
      frame_error_next     = ERR_NONE;
      comment_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      position_offset <= '0;
      lat_degrees     <= '0;
      lat_minutes     <= '0;
      lon_degrees     <= '0;
      lon_minutes     <= '0;
      hemisphere      <= '0;
      held_symbols    <= '0;
      frame_error     <= ERR_NONE;
      comment_count   <= '0;
    end else if (step) begin
      byte_position   <= byte_position_next;
      position_offset <= position_offset_next;
      lat_degrees     <= lat_degrees_next;
      lat_minutes     <= lat_minutes_next;
      lon_degrees     <= lon_degrees_next;
      lon_minutes     <= lon_minutes_next;
      hemisphere      <= hemisphere_next;
      held_symbols    <= held_symbols_next;
      frame_error     <= frame_error_next;
      comment_count   <= comment_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/aprs_result_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aprs_result_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push_a,
  input  aprs_pkg::aprs_result_t       data_a,
  input  logic                         push_b,
  input  aprs_pkg::aprs_result_t       data_b,
  input  logic                         pop,
  output aprs_pkg::aprs_result_t       head,
  output aprs_pkg::aprs_queue_status_t status
);
  import aprs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  aprs_result_t   mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic [AW-1:0]  wr_ptr_inc;
  logic [AW-1:0]  slot_b;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) return '0;
    return p + AW'(1);
  endfunction

  assign wr_ptr_inc = ptr_inc(wr_ptr);
  assign slot_b     = push_a ? wr_ptr_inc : wr_ptr;

  assign head                = mem[rd_ptr];
  assign status.not_empty    = (count != '0);
  assign status.room_for_two = (count <= CW'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_a) mem[wr_ptr] <= data_a;
    if (push_b) mem[slot_b] <= data_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_b) begin
        wr_ptr <= ptr_inc(slot_b);
      end else if (push_a) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      count <= count + CW'(push_a) + CW'(push_b) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/aprs_position_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: an accepted byte is held in the input register, decoded and written to the result queue
// throughput: one byte per cycle while the queue can hold two words; a last byte that
//   also carries a comment byte gives two words, the comment word ahead of the record
// a four-word result queue decouples the sides; input stalls when it cannot hold two words
// reset: synchronous, clears the frame state, the input register's valid bit and the result queue

module aprs_position_parser #(
  parameter int COMMENT_MAX = 63
) (
  input  logic        clk,
  input  logic        rst,
  // slave side: input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  // master side: comment bytes and position records
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] comment_char, [28:8] latitude, [50:29] longitude,
                                 // [58:51] sym_table, [66:59] sym_code,
                                 // [67] pos_valid, [70:68] error_code,
                                 // [76:71] comment_length, [79:77] zero
  output logic        m_tuser,   // kind
  output logic        m_tlast    // record_last
);
  import aprs_pkg::*;

  // comment limit saturates at what the 6-bit count can show
  localparam int COMMENT_LIMIT = (COMMENT_MAX > 63) ? 63 : COMMENT_MAX;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       proc;

  aprs_emit_t         emit;
  aprs_result_t       head;
  aprs_queue_status_t qstat;

  // the byte in the input register is decoded once the queue can take both possible words
  assign proc     = in_valid && qstat.room_for_two;
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // frame decoder: per-byte digit accumulation and range checks
  aprs_frame_decoder #(
    .COMMENT_LIMIT(COMMENT_LIMIT)
  ) u_decoder (
    .clk      (clk),
    .rst      (rst),
    .step     (proc),
    .data_byte(in_byte),
    .last_byte(in_last),
    .emit     (emit)
  );

  // result queue: comment word goes in ahead of the record
  aprs_result_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push_a(proc && emit.comment_valid),
    .data_a(emit.comment),
    .push_b(proc && emit.record_valid),
    .data_b(emit.record),
    .pop   (m_tvalid && m_tready),
    .head  (head),
    .status(qstat)
  );

  assign m_tvalid = qstat.not_empty;
  assign m_tuser  = head.kind;
  assign m_tlast  = head.record_last;
  assign m_tdata  = {3'b000, head.comment_length, head.error_code, head.pos_valid,
                     head.sym_code, head.sym_table, head.longitude, head.latitude,
                     head.comment_char};

  // a record is always the last word of its frame and a comment word never is
  a_last_is_record: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == m_tuser))
    else $error("record_last and kind disagree");

  // a failed record carries no position and no comment length
  a_error_record_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && head.error_code != ERR_NONE) |->
      (!head.pos_valid && head.comment_length == '0 && head.latitude == '0))
    else $error("error record carries position data");

  // a comment word carries only its byte
  a_comment_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[79:8] == '0))
    else $error("comment word carries record fields");

  // leaving reset the block is empty and ready
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (s_tready && !m_tvalid))
    else $error("block not empty after reset");

endmodule

`default_nettype wire
